// File: hdl/bse_pkg.sv
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and the sextet-to-ASCII map for the base64 encoder.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int CHAR_W     = 7;
  localparam int MAX_CHARS  = 4;
  localparam int FIFO_DEPTH = 4;                 // power of two, pointers wrap
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CHAR_W-1:0] CH_PAD = 7'h3D;  // '='

  typedef enum logic [1:0] {
    POS0 = 2'd0,
    POS1 = 2'd1,
    POS2 = 2'd2
  } pos_t;

  // One byte's worth of output characters, queued between front and back.
  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [1:0]                       cnt_m1;   // characters in entry minus one
    logic                             last;     // final char carries the message end
  } grp_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
    logic [CHAR_W-1:0] c;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// File: hdl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Input channel: one message byte per beat on in_tdata, in_tlast marks the
// final byte. Output channel: one ASCII character per beat on out_tdata,
// out_tlast marks the final character of the encoded message.
// Bytes 1 and 2 of a group give one character each, byte 3 gives two; the last
// byte flushes the partial group with padding (up to four characters).
// Each byte is registered into the queue and then into the output register
// before its first character is valid. Throughput: one output character per
// cycle from the single output register while the receiver is ready and the
// queue holds an entry, so a steady stream gives 4 characters per 3 input bytes.
// A 4-entry queue of character groups sits between the byte front end and the
// character output, so input keeps flowing while the receiver stalls until the
// queue fills; in_tready then drops. The output holds its beat while stalled.
// Reset (synchronous, rst_n low) returns to the start of a group and empties
// the queue and the output register.
// ----------------------------------------------------------------------------
module base64_stream_encoder import bse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // is_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tlast   // out_last
);

  grp_t              fr_grp;
  grp_t              head;
  logic              acc;
  logic              pop;
  logic              full;
  logic              empty;
  logic [CHAR_W-1:0] ch;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  bse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_tdata),
    .is_last   (in_tlast),
    .grp       (fr_grp)
  );

  bse_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (acc),
    .wr_grp (fr_grp),
    .pop    (pop),
    .rd_grp (head),
    .full   (full),
    .empty  (empty)
  );

  bse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (ch),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, ch};

endmodule

// File: hdl/bse_front.sv
// ----------------------------------------------------------------------------
// bse_front
// Tracks the position in the 3-byte group and the carried bits, and turns each
// accepted byte into a queue entry of one to four characters.
// ----------------------------------------------------------------------------
module bse_front import bse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output grp_t       grp
);

  pos_t       pos_r, pos_nxt;
  logic [3:0] left_r, left_nxt;

  always_comb begin
    grp          = '0;
    grp.chars[2] = CH_PAD;
    grp.chars[3] = CH_PAD;
    pos_nxt      = pos_r;
    left_nxt     = left_r;
    unique case (pos_r)
      POS1: begin
        grp.chars[0] = sextet_char({left_r[1:0], data_byte[7:4]});
        if (is_last) begin
          grp.chars[1] = sextet_char({data_byte[3:0], 2'b00});
          grp.cnt_m1   = 2'd2;
          grp.last     = 1'b1;
          pos_nxt      = POS0;
          left_nxt     = '0;
        end else begin
          grp.cnt_m1 = 2'd0;
          pos_nxt    = POS2;
          left_nxt   = data_byte[3:0];
        end
      end
      POS2: begin
        grp.chars[0] = sextet_char({left_r, data_byte[7:6]});
        grp.chars[1] = sextet_char(data_byte[5:0]);
        grp.cnt_m1   = 2'd1;
        grp.last     = is_last;
        pos_nxt      = POS0;
        left_nxt     = '0;
      end
      default: begin
        grp.chars[0] = sextet_char(data_byte[7:2]);
        if (is_last) begin
          grp.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
          grp.cnt_m1   = 2'd3;
          grp.last     = 1'b1;
          pos_nxt      = POS0;
          left_nxt     = '0;
        end else begin
          grp.cnt_m1 = 2'd0;
          pos_nxt    = POS1;
          left_nxt   = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS0;
      left_r <= '0;
    end else if (acc) begin
      pos_r  <= pos_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// File: hdl/bse_fifo.sv
// ----------------------------------------------------------------------------
// bse_fifo
// Short register queue of character groups between front and back.
// ----------------------------------------------------------------------------
module bse_fifo import bse_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t wr_grp,
  input  logic pop,
  output grp_t rd_grp,
  output logic full,
  output logic empty
);

  grp_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full   = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_grp = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_grp;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("queue count exceeds depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == cnt_r[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: hdl/bse_back.sv
// ----------------------------------------------------------------------------
// bse_back
// Walks the head queue entry one character per beat into the output register.
// ----------------------------------------------------------------------------
module bse_back import bse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  grp_t              head,
  input  logic              head_valid,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic [1:0]        idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic              load;
  logic              at_end;

  assign load   = head_valid && (!vld_r || out_ready);
  assign at_end = (idx_r == head.cnt_m1);
  assign pop    = load && at_end;

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= head.chars[idx_r];
      last_r <= head.last && at_end;
    end
  end

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

// File: tb/base64_checker.sv
// ----------------------------------------------------------------------------
// base64_checker
// Watches both streams of the base64 encoder. For each input beat it works out
// the characters the byte completes and queues them. Each output beat is
// compared with the oldest queued character.
// ----------------------------------------------------------------------------
module base64_checker import bse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // is_last
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  input  logic       out_tlast,  // out_last
  output int         error_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } enc_char_t;

  // index 0 is 'A' in the top byte of the literal
  localparam logic [0:63][7:0] B64_SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   expected_chars[$];
  enc_char_t   oldest;
  pos_t        group_pos;
  logic [3:0]  carry_bits;

  function automatic logic [CHAR_W-1:0] symbol_of(input logic [5:0] idx);
    logic [7:0] c;
    c = B64_SYMBOLS[idx];
    return c[CHAR_W-1:0];
  endfunction

  task automatic queue_char(input logic [CHAR_W-1:0] ch, input logic last);
    enc_char_t e;
    e.ch   = ch;
    e.last = last;
    expected_chars.push_back(e);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic msg_end);
    case (group_pos)
      POS1: begin
        queue_char(symbol_of({carry_bits[1:0], b[7:4]}), 1'b0);
        if (msg_end) begin
          queue_char(symbol_of({b[3:0], 2'b00}), 1'b0);
          queue_char(CH_PAD, 1'b1);
          group_pos  = POS0;
          carry_bits = '0;
        end else begin
          carry_bits = b[3:0];
          group_pos  = POS2;
        end
      end
      POS2: begin
        queue_char(symbol_of({carry_bits, b[7:6]}), 1'b0);
        queue_char(symbol_of(b[5:0]), msg_end);
        group_pos  = POS0;
        carry_bits = '0;
      end
      default: begin
        queue_char(symbol_of(b[7:2]), 1'b0);
        if (msg_end) begin
          queue_char(symbol_of({b[1:0], 4'b0000}), 1'b0);
          queue_char(CH_PAD, 1'b0);
          queue_char(CH_PAD, 1'b1);
          group_pos  = POS0;
          carry_bits = '0;
        end else begin
          carry_bits = {2'b00, b[1:0]};
          group_pos  = POS1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_chars.delete();
      group_pos   = POS0;
      carry_bits  = '0;
      error_count = 0;
    end else begin
      // an output beat can never stem from the input beat of the same edge
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected output beat: char %h last %b", out_tdata, out_tlast);
          error_count++;
        end else begin
          oldest = expected_chars.pop_front();
          if (out_tdata[CHAR_W-1:0] !== oldest.ch) begin
            $error("out_char mismatch: expected %h, got %h", oldest.ch,
                   out_tdata[CHAR_W-1:0]);
            error_count++;
          end
          if (out_tdata[7] !== 1'b0) begin
            $error("out_tdata[7] mismatch: expected 0, got %b", out_tdata[7]);
            error_count++;
          end
          if (out_tlast !== oldest.last) begin
            $error("out_last mismatch: expected %b, got %b", oldest.last, out_tlast);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
      end
    end
    pending_count <= expected_chars.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the streaming base64 encoder. Sends directed messages (byte
// extremes, every padding case, '+' and '/') and then random messages, with
// random gaps on both sides and one long receiver hold-off. The checker
// predicts and compares every character.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_BYTES  = 260;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 150;
  localparam int IDLE_PCT    = 28;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  int error_count;
  int pending_count;
  int cycle_count = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  base64_stream_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  base64_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic msg_end);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= msg_end;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int sent;
    int msg_len;
    int mode;
    logic [7:0] b;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-byte messages at the extremes: "==" padding
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    // two bytes: "=" padding
    send_beat(8'h4D, 1'b0);
    send_beat(8'h61, 1'b1);
    // full group
    send_beat(8'h4D, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'h6E, 1'b1);
    // "+/+/"
    send_beat(8'hFB, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hBF, 1'b1);
    // message ends at group position one
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    // message ends at group position two
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);

    while (sent < RAND_BYTES) begin
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
      for (int i = 0; i < msg_len; i++) begin
        // a stretch without gaps on either side
        gaps_on = !(sent >= 150 && sent < 210);
        if (sent == 80) begin
          hold_req = 1'b1;
        end
        mode = $urandom_range(9);
        if (mode == 0) begin
          b = 8'h00;
        end else if (mode == 1) begin
          b = 8'hFF;
        end else begin
          b = 8'($urandom_range(255));
        end
        send_beat(b, i == msg_len - 1);
        sent++;
      end
    end
    gaps_on = 1'b1;
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
